/* design/touch_event_sanitizer_unit_defines.svh */
// Assertion macros shared by the touch event sanitizer RTL.
`ifndef TOUCH_EVENT_SANITIZER_UNIT_DEFINES_SVH
`define TOUCH_EVENT_SANITIZER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TES_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch event sanitizer: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch event sanitizer: next-cycle check failed");

`endif

/* design/tes_pkg.sv */
// Types and constants shared by the touch event sanitizer.
`timescale 1ns / 1ps

package tes_pkg;

    // Fixed field widths of the stream words.
    localparam int TASK_W     = 3;
    localparam int TIME_W     = 32;
    localparam int COORD_W    = 12;
    localparam int FLAGS_W    = 3;
    localparam int LIMIT_W    = 16;
    localparam int EVENT_W    = 2;

    // Input word: task, time, start, move, end, x, y from bit 0 up.
    localparam int IN_TASK_LSB  = 0;
    localparam int IN_TIME_LSB  = IN_TASK_LSB + TASK_W;
    localparam int IN_FLAGS_LSB = IN_TIME_LSB + TIME_W;
    localparam int IN_X_LSB     = IN_FLAGS_LSB + FLAGS_W;
    localparam int IN_Y_LSB     = IN_X_LSB + COORD_W;
    localparam int IN_BITS      = IN_Y_LSB + COORD_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Output word: x, y, ready from bit 0 up.
    localparam int OUT_X_LSB     = 0;
    localparam int OUT_Y_LSB     = OUT_X_LSB + COORD_W;
    localparam int OUT_READY_BIT = OUT_Y_LSB + COORD_W;
    localparam int OUT_BITS      = OUT_READY_BIT + 1;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // Bit positions inside the three-bit flag group.
    localparam int FL_START_BIT = 0;
    localparam int FL_MOVE_BIT  = 1;
    localparam int FL_END_BIT   = 2;

    localparam logic [FLAGS_W-1:0] FLAGS_NONE       = 3'b000;
    localparam logic [FLAGS_W-1:0] FLAGS_START_ONLY = 3'b001;

    localparam logic [LIMIT_W-1:0] STARVE_LIMIT_RESET = 16'd300;

    typedef enum logic [0:0] {
        KIND_POLL  = 1'b0,
        KIND_CLEAR = 1'b1
    } item_kind_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_MOVE  = 2'd2,
        EV_END   = 2'd3
    } event_kind_t;

endpackage

/* design/touch_event_sanitizer_unit.sv */
// Touch event sanitizer top: per-task touch cleanup, one word/cycle unless stalled.
`timescale 1ns / 1ps
`include "touch_event_sanitizer_unit_defines.svh"

// Touch event sanitizer. Each input word names a task and carries either a
// raw touch poll (millisecond time, start/move/end flags and x, y) or a
// request to clear that task's context. The block keeps one context per task
// and returns exactly one result word per input word: a clean start, move or
// end event (or none), its coordinates, and a ready flag that tells whether
// the sample differs from the stored last state. A missed end is made up when
// a start arrives at new coordinates with the finger still down, and a missed
// start is made up from a move, or from an end at new coordinates when the
// previous poll of the task came no later than starve_limit_ms before. The
// block takes one word every clock cycle while the output is not stalled; a
// word sits in the input register, where its task context is read, decided
// on and written back, and then moves on to the result register, which
// drives the output. A new word can be taken into an empty input register
// while a finished result still waits in the result register. Words whose
// task is at or above TASK_COUNT leave all contexts alone and give an
// all-zero result, as does a clear word. The user must write the starve
// limit through cfg_wr_en / cfg_wr_data only while no word is in flight;
// the block itself does not enforce this.
module touch_event_sanitizer_unit #(
    parameter int TASK_COUNT  = 8,
    parameter int COORD_WIDTH = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // task_req[2:0], now_ms[34:3], start_flag[35], move_flag[36],
    // end_flag[37], touch_x[49:38], touch_y[61:50], zero fill above.
    input  logic [tes_pkg::IN_TDATA_W-1:0]    s_tdata,
    // kind[0].
    input  logic                              s_tuser,
    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // event_x[11:0], event_y[23:12], ready_res[24], zero fill above.
    output logic [tes_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // event_kind[1:0].
    output logic [tes_pkg::EVENT_W-1:0]       m_tuser,
    // Starve limit register write.
    input  logic                              cfg_wr_en,
    input  logic [tes_pkg::LIMIT_W-1:0]       cfg_wr_data
);
    import tes_pkg::*;

    // Width of a context index; a single task still needs one bit.
    localparam int IDX_W  = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    // Scratch width for widening or narrowing coordinates and task numbers.
    localparam int CEXT_W = (COORD_WIDTH > COORD_W) ? COORD_WIDTH : COORD_W;
    localparam int TEXT_W = TASK_W + IDX_W;

    // Input register.
    logic                     in_valid_reg;
    item_kind_t               in_kind_reg;
    logic [TASK_W-1:0]        in_task_reg;
    logic [TIME_W-1:0]        in_time_reg;
    logic [FLAGS_W-1:0]       in_flags_reg;
    logic [COORD_W-1:0]       in_x_reg;
    logic [COORD_W-1:0]       in_y_reg;

    // Result register.
    logic                     out_valid_reg;
    event_kind_t              ev_kind_reg;
    logic [COORD_W-1:0]       ev_x_reg;
    logic [COORD_W-1:0]       ev_y_reg;
    logic                     ready_reg;

    // Starve limit and per-task contexts.
    logic [LIMIT_W-1:0]       starve_limit_reg;
    logic [TIME_W-1:0]        last_poll_reg   [TASK_COUNT];
    logic [FLAGS_W-1:0]       last_flags_reg  [TASK_COUNT];
    logic                     finger_down_reg [TASK_COUNT];
    logic [COORD_WIDTH-1:0]   prev_x_reg      [TASK_COUNT];
    logic [COORD_WIDTH-1:0]   prev_y_reg      [TASK_COUNT];

    // Next values for the addressed context and the result register.
    logic [FLAGS_W-1:0]       ctx_flags_next;
    logic                     ctx_down_next;
    event_kind_t              ev_kind_next;
    logic [COORD_WIDTH-1:0]   ev_x_int;
    logic [COORD_WIDTH-1:0]   ev_y_int;
    logic [COORD_W-1:0]       ev_x_next;
    logic [COORD_W-1:0]       ev_y_next;
    logic                     ready_next;

    // Handshake and decode.
    logic                     in_accept;
    logic                     advance;
    logic                     ctx_write;
    logic                     in_range;
    logic [TEXT_W-1:0]        task_ext;
    logic [IDX_W-1:0]         idx;
    logic [CEXT_W-1:0]        x_ext;
    logic [CEXT_W-1:0]        y_ext;
    logic [CEXT_W-1:0]        ex_ext;
    logic [CEXT_W-1:0]        ey_ext;
    logic [COORD_WIDTH-1:0]   cur_x;
    logic [COORD_WIDTH-1:0]   cur_y;
    logic [TIME_W-1:0]        gap;
    logic                     starving;
    logic                     moved;
    logic                     down;
    logic [FLAGS_W-1:0]       stored_flags;

    // The result register takes a new word whenever it is empty or being
    // drained; the input register empties into it at the same edge.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign ctx_write = advance && in_valid_reg && in_range;

    assign task_ext = TEXT_W'(in_task_reg);
    assign idx      = task_ext[IDX_W-1:0];
    assign in_range = (32'(in_task_reg) < 32'(TASK_COUNT));

    // Coordinates are kept at COORD_WIDTH bits inside the block.
    assign x_ext = CEXT_W'(in_x_reg);
    assign y_ext = CEXT_W'(in_y_reg);
    assign cur_x = x_ext[COORD_WIDTH-1:0];
    assign cur_y = y_ext[COORD_WIDTH-1:0];

    assign stored_flags = last_flags_reg[idx];
    assign down         = finger_down_reg[idx];
    assign moved        = (cur_x != prev_x_reg[idx]) || (cur_y != prev_y_reg[idx]);

    // The poll gap is read as a signed value; a negative gap never starves.
    assign gap      = in_time_reg - last_poll_reg[idx];
    assign starving = !gap[TIME_W-1] && (gap > TIME_W'(starve_limit_reg));

    // Event decision for a poll word. Start wins over move, move over end.
    always_comb
    begin
        ev_kind_next   = EV_NONE;
        ev_x_int       = '0;
        ev_y_int       = '0;
        ctx_flags_next = in_flags_reg;
        ready_next     = 1'b0;
        if (in_range && (in_kind_reg == KIND_POLL))
        begin
            ready_next = (in_flags_reg != stored_flags) || moved;
            if (in_flags_reg[FL_START_BIT])
            begin
                if (!down)
                begin
                    ev_kind_next = EV_START;
                    ev_x_int     = cur_x;
                    ev_y_int     = cur_y;
                end
                else if (moved)
                begin
                    // Missed end: close the old touch where it was.
                    ev_kind_next = EV_END;
                    ev_x_int     = prev_x_reg[idx];
                    ev_y_int     = prev_y_reg[idx];
                end
            end
            else if (in_flags_reg[FL_MOVE_BIT])
            begin
                if (!down || stored_flags[FL_START_BIT] || moved)
                begin
                    // With the finger up this is a missed start.
                    ev_kind_next = down ? EV_MOVE : EV_START;
                    ev_x_int     = cur_x;
                    ev_y_int     = cur_y;
                end
            end
            else if (in_flags_reg[FL_END_BIT])
            begin
                if (down)
                begin
                    ev_kind_next = EV_END;
                    ev_x_int     = cur_x;
                    ev_y_int     = cur_y;
                end
                else if (!starving && moved)
                begin
                    // Missed start on a short tap; remember it as a start.
                    ev_kind_next   = EV_START;
                    ev_x_int       = cur_x;
                    ev_y_int       = cur_y;
                    ctx_flags_next = FLAGS_START_ONLY;
                end
            end
        end
    end

    always_comb
    begin
        ctx_down_next = down;
        case (ev_kind_next)
            EV_START: ctx_down_next = 1'b1;
            EV_MOVE:  ctx_down_next = 1'b1;
            EV_END:   ctx_down_next = 1'b0;
            default:  ctx_down_next = down;
        endcase
    end

    assign ex_ext    = CEXT_W'(ev_x_int);
    assign ey_ext    = CEXT_W'(ev_y_int);
    assign ev_x_next = ex_ext[COORD_W-1:0];
    assign ev_y_next = ey_ext[COORD_W-1:0];

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_kind_reg  <= item_kind_t'(s_tuser);
            in_task_reg  <= s_tdata[IN_TASK_LSB +: TASK_W];
            in_time_reg  <= s_tdata[IN_TIME_LSB +: TIME_W];
            in_flags_reg <= s_tdata[IN_FLAGS_LSB +: FLAGS_W];
            in_x_reg     <= s_tdata[IN_X_LSB +: COORD_W];
            in_y_reg     <= s_tdata[IN_Y_LSB +: COORD_W];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            ev_kind_reg <= ev_kind_next;
            ev_x_reg    <= ev_x_next;
            ev_y_reg    <= ev_y_next;
            ready_reg   <= ready_next;
        end
    end

    // Starve limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            starve_limit_reg <= STARVE_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            starve_limit_reg <= cfg_wr_data;
        end
    end

    // Task contexts: written back at the same edge the word leaves the
    // input register, so the next word already sees the update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TASK_COUNT; t++)
            begin
                last_poll_reg[t]   <= '0;
                last_flags_reg[t]  <= FLAGS_NONE;
                finger_down_reg[t] <= 1'b0;
                prev_x_reg[t]      <= '0;
                prev_y_reg[t]      <= '0;
            end
        end
        else if (ctx_write)
        begin
            last_poll_reg[idx] <= in_time_reg;
            if (in_kind_reg == KIND_CLEAR)
            begin
                last_flags_reg[idx]  <= FLAGS_NONE;
                finger_down_reg[idx] <= 1'b0;
                prev_x_reg[idx]      <= '0;
                prev_y_reg[idx]      <= '0;
            end
            else
            begin
                last_flags_reg[idx]  <= ctx_flags_next;
                finger_down_reg[idx] <= ctx_down_next;
                prev_x_reg[idx]      <= cur_x;
                prev_y_reg[idx]      <= cur_y;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ev_kind_reg;
    assign m_tdata  = OUT_TDATA_W'({ready_reg, ev_y_reg, ev_x_reg});

    // The input side only stalls while a word sits in the input register.
    `TES_ASSERT_SAME(a_stall_needs_word, clk, rst_n, !s_tready, in_valid_reg)
    // A word leaving the input register always lands in the result register.
    `TES_ASSERT_NEXT(a_word_lands, clk, rst_n, advance && in_valid_reg, out_valid_reg)
    // A clear word leaves its task lifted and stamped with its time.
    `TES_ASSERT_NEXT(a_clear_context, clk, rst_n,
        ctx_write && (in_kind_reg == KIND_CLEAR),
        !finger_down_reg[$past(idx)] && (last_poll_reg[$past(idx)] == $past(in_time_reg)))
    // An end event always lifts the finger of its task.
    `TES_ASSERT_NEXT(a_end_lifts, clk, rst_n, ctx_write && (ev_kind_next == EV_END),
        !finger_down_reg[$past(idx)] && (ev_kind_reg == EV_END))
    // A word without an event carries zero coordinates.
    `TES_ASSERT_SAME(a_none_zero_xy, clk, rst_n, out_valid_reg && (ev_kind_reg == EV_NONE),
        (ev_x_reg == '0) && (ev_y_reg == '0))

endmodule

/* verif/touch_event_sanitizer_unit_test.sv */
// Self-checking testbench for the touch event sanitizer: directed and random touch streams.
`timescale 1ns / 1ps

// One expected or observed result word.
typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] x;
    logic [11:0] y;
    logic        ready;
} touch_result_t;

// Tracks the per-task touch contexts and holds the event words that are owed.
class touch_event_tracker;
    logic [15:0]   starve_limit;
    logic [31:0]   poll_ms [8];
    logic [2:0]    flags_seen [8];
    logic          pressed [8];
    logic [11:0]   last_x [8];
    logic [11:0]   last_y [8];
    touch_result_t pending_events [$];
    int            failures;
    int            reported;

    function new();
        starve_limit = tes_pkg::STARVE_LIMIT_RESET;
        for (int t = 0; t < 8; t++)
        begin
            poll_ms[t] = '0;
            flags_seen[t] = tes_pkg::FLAGS_NONE;
            pressed[t] = 1'b0;
            last_x[t] = '0;
            last_y[t] = '0;
        end
        failures = 0;
        reported = 0;
    endfunction

    function void flag_failure(string what);
        failures++;
        if (reported < 10)
        begin
            reported++;
            $display("[%0t] %s", $time, what);
        end
    endfunction

    // Works out the event word for one accepted input word and updates the context.
    function void note_word(tes_pkg::item_kind_t kind, logic [2:0] tid, logic [31:0] now,
                            logic [2:0] flags, logic [11:0] x, logic [11:0] y);
        touch_result_t res;
        logic [31:0]   gap;
        logic          starving;
        logic          moved;
        logic          down;
        logic [2:0]    new_flags;
        res.kind = tes_pkg::EV_NONE;
        res.x = '0;
        res.y = '0;
        res.ready = 1'b0;
        if (kind == tes_pkg::KIND_CLEAR)
        begin
            poll_ms[tid] = now;
            flags_seen[tid] = tes_pkg::FLAGS_NONE;
            pressed[tid] = 1'b0;
            last_x[tid] = '0;
            last_y[tid] = '0;
        end
        else
        begin
            moved = (x != last_x[tid]) || (y != last_y[tid]);
            res.ready = (flags != flags_seen[tid]) || moved;
            // A gap with the sign bit set is a poll from the past and never starves.
            gap = now - poll_ms[tid];
            starving = !gap[31] && (gap > {16'd0, starve_limit});
            poll_ms[tid] = now;
            down = pressed[tid];
            new_flags = flags;
            if (flags[tes_pkg::FL_START_BIT])
            begin
                if (!down)
                begin
                    res.kind = tes_pkg::EV_START;
                    res.x = x;
                    res.y = y;
                end
                else if (moved)
                begin
                    // The lift was missed: close the old touch where it was.
                    res.kind = tes_pkg::EV_END;
                    res.x = last_x[tid];
                    res.y = last_y[tid];
                end
            end
            else if (flags[tes_pkg::FL_MOVE_BIT])
            begin
                if (!down || flags_seen[tid][tes_pkg::FL_START_BIT] || moved)
                begin
                    res.kind = down ? tes_pkg::EV_MOVE : tes_pkg::EV_START;
                    res.x = x;
                    res.y = y;
                end
            end
            else if (flags[tes_pkg::FL_END_BIT])
            begin
                if (down)
                begin
                    res.kind = tes_pkg::EV_END;
                    res.x = x;
                    res.y = y;
                end
                else if (!starving && moved)
                begin
                    // A whole tap fell between two polls: report its start.
                    res.kind = tes_pkg::EV_START;
                    res.x = x;
                    res.y = y;
                    new_flags = tes_pkg::FLAGS_START_ONLY;
                end
            end
            if (res.kind == tes_pkg::EV_START || res.kind == tes_pkg::EV_MOVE)
                pressed[tid] = 1'b1;
            else if (res.kind == tes_pkg::EV_END)
                pressed[tid] = 1'b0;
            last_x[tid] = x;
            last_y[tid] = y;
            flags_seen[tid] = new_flags;
        end
        pending_events.push_back(res);
    endfunction

    // Compares one result word with the oldest owed event word.
    function void check_event(logic [1:0] kind, logic [11:0] x, logic [11:0] y, logic ready);
        touch_result_t owed;
        if (pending_events.size() == 0)
        begin
            flag_failure($sformatf("unexpected result: kind %0d x %0d y %0d ready %0d",
                                   kind, x, y, ready));
            return;
        end
        owed = pending_events.pop_front();
        if (owed.kind !== kind || owed.x !== x || owed.y !== y || owed.ready !== ready)
            flag_failure($sformatf({"result mismatch: expected kind %0d x %0d y %0d ready %0d,",
                                    " got kind %0d x %0d y %0d ready %0d"},
                                   owed.kind, owed.x, owed.y, owed.ready, kind, x, y, ready));
    endfunction
endclass

module touch_event_sanitizer_unit_test;
    import tes_pkg::*;

    localparam logic [2:0] F_START = FLAGS_START_ONLY;
    localparam logic [2:0] F_MOVE  = 3'b001 << FL_MOVE_BIT;
    localparam logic [2:0] F_END   = 3'b001 << FL_END_BIT;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_WORDS     = 192;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [EVENT_W-1:0]     m_tuser;
    logic                   cfg_wr_en;
    logic [LIMIT_W-1:0]     cfg_wr_data;

    touch_event_tracker tracker;

    // Idle percentages of the current phase, and the limit the block now holds.
    int send_idle_pct;
    int recv_stall_pct;
    int cur_limit;

    // Stimulus-side memory per task: last time sent and the gesture in progress.
    logic [31:0] sent_ms [8];
    int          gest_step [8];
    logic [2:0]  gest_flags [8];
    logic [11:0] gest_x [8];
    logic [11:0] gest_y [8];

    touch_event_sanitizer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 clk = ~clk;

    // The receiver decides at each falling edge whether it stalls the next cycle.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Result words are taken at the rising edge where valid and ready meet.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_event(m_tuser, m_tdata[OUT_X_LSB +: COORD_W],
                                m_tdata[OUT_Y_LSB +: COORD_W], m_tdata[OUT_READY_BIT]);
    end

    // Hard stop in case the block hangs somewhere.
    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Number of idle cycles the sender inserts before its next word.
    function automatic int idle_gap();
        int n;
        n = 0;
        while (n < 12 && $urandom_range(99) < send_idle_pct)
            n++;
        return n;
    endfunction

    // Mostly small finger travel, some edge coordinates, some jumps anywhere.
    function automatic logic [11:0] pick_coord(logic [11:0] old);
        int          r;
        logic [11:0] step;
        r = $urandom_range(99);
        step = 12'($urandom_range(1, 15));
        if (r < 8)
            return 12'h000;
        if (r < 16)
            return 12'hFFF;
        if (r < 60)
            return $urandom_range(1) ? old + step : old - step;
        return 12'($urandom_range(4095));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(item_kind_t kind, logic [2:0] tid, logic [31:0] now,
                             logic [2:0] flags, logic [11:0] x, logic [11:0] y);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, y, x, flags, now, tid};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_word(kind, tid, now, flags, x, y);
        sent_ms[tid] = now;
        @(negedge clk);
    endtask

    // Stops sending and waits until every owed event word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (tracker.pending_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_starve_limit(logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.starve_limit = value;
        cur_limit = int'(value);
    endtask

    // One random word: mostly gestures (start, moves, end) per task with the
    // usual faults mixed in, plus raw flag noise and context clears.
    task automatic random_word();
        int          r;
        logic [2:0]  tid;
        logic [31:0] now;
        logic [2:0]  flags;
        logic [11:0] x;
        logic [11:0] y;
        item_kind_t  kind;
        tid = 3'($urandom_range(7));
        kind = KIND_POLL;

        // Poll time against the task's last word: inside the limit, past it,
        // right on its edge, back in time, or anywhere at all.
        r = $urandom_range(99);
        if (r < 60)
            now = sent_ms[tid] + $urandom_range(cur_limit);
        else if (r < 75)
            now = sent_ms[tid] + cur_limit + $urandom_range(1, 1000);
        else if (r < 83)
            now = sent_ms[tid] + cur_limit + $urandom_range(1);
        else if (r < 90)
            now = sent_ms[tid] - $urandom_range(1, 5000);
        else
            now = $urandom;

        x = gest_x[tid];
        y = gest_y[tid];
        r = $urandom_range(99);
        if (r < 8)
        begin
            // Clear, with junk in the sample fields.
            kind = KIND_CLEAR;
            flags = 3'($urandom_range(7));
            x = 12'($urandom_range(4095));
            y = 12'($urandom_range(4095));
            gest_step[tid] = 0;
            gest_flags[tid] = FLAGS_NONE;
            gest_x[tid] = '0;
            gest_y[tid] = '0;
        end
        else
        begin
            if (r < 25)
            begin
                flags = 3'($urandom_range(7));
                if ($urandom_range(1))
                begin
                    x = pick_coord(x);
                    y = pick_coord(y);
                end
            end
            else if (gest_step[tid] == 0)
            begin
                // Touch down; now and then the start itself was missed.
                r = $urandom_range(99);
                flags = (r < 80) ? F_START : (r < 90) ? F_MOVE : F_END;
                x = pick_coord(x);
                y = pick_coord(y);
                gest_step[tid] = 1;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 55)
                begin
                    flags = F_MOVE;
                    if ($urandom_range(99) < 85)
                    begin
                        x = pick_coord(x);
                        y = pick_coord(y);
                    end
                    gest_step[tid]++;
                end
                else if (r < 68)
                begin
                    // Bounce: the very same sample again.
                    flags = gest_flags[tid];
                end
                else if (r < 78)
                begin
                    // The lift was missed and a new touch starts elsewhere.
                    flags = F_START;
                    x = pick_coord(x);
                    y = pick_coord(y);
                    gest_step[tid] = 1;
                end
                else
                begin
                    flags = F_END;
                    if ($urandom_range(99) < 15)
                    begin
                        x = pick_coord(x);
                        y = pick_coord(y);
                    end
                    gest_step[tid] = 0;
                end
            end
            gest_flags[tid] = flags;
            gest_x[tid] = x;
            gest_y[tid] = y;
        end
        send_word(kind, tid, now, flags, x, y);
    endtask

    initial
    begin
        logic [15:0] phase_limit [RANDOM_PHASES];
        int          phase_send  [RANDOM_PHASES];
        int          phase_recv  [RANDOM_PHASES];

        tracker = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_limit = int'(STARVE_LIMIT_RESET);
        for (int t = 0; t < 8; t++)
        begin
            sent_ms[t] = '0;
            gest_step[t] = 0;
            gest_flags[t] = FLAGS_NONE;
            gest_x[t] = '0;
            gest_y[t] = '0;
        end

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, run with the reset starve limit of 300 ms.
        // A clean touch, then a repeated move that must be dropped.
        send_word(KIND_POLL, 3'd0, 32'd100, F_START, 12'h000, 12'h000);
        send_word(KIND_POLL, 3'd0, 32'd110, F_MOVE, 12'hFFF, 12'hFFF);
        send_word(KIND_POLL, 3'd0, 32'd120, F_MOVE, 12'hFFF, 12'hFFF);
        // A start at new coordinates while down closes the old touch at the old spot.
        send_word(KIND_POLL, 3'd0, 32'd130, F_START, 12'd5, 12'd6);
        send_word(KIND_POLL, 3'd0, 32'd140, F_END, 12'd5, 12'd6);
        // A move with the finger up stands in for the missed start.
        send_word(KIND_POLL, 3'd0, 32'd150, F_MOVE, 12'd7, 12'd8);
        send_word(KIND_POLL, 3'd0, 32'd160, F_END, 12'd7, 12'd8);
        // An end at new coordinates exactly at the limit still counts as a tap start.
        send_word(KIND_POLL, 3'd0, 32'd460, F_END, 12'd9, 12'd9);
        send_word(KIND_POLL, 3'd0, 32'd470, F_END, 12'd9, 12'd9);
        // One millisecond past the limit the poller is starving and nothing is made up.
        send_word(KIND_POLL, 3'd0, 32'd771, F_END, 12'd10, 12'd10);
        // A poll from the past never counts as starving.
        send_word(KIND_POLL, 3'd0, 32'd700, F_END, 12'd11, 12'd11);
        send_word(KIND_POLL, 3'd0, 32'd710, F_END, 12'd11, 12'd11);
        // All flags at once: start wins. Then time wraps and the flags go quiet.
        send_word(KIND_POLL, 3'd1, 32'hFFFF_FFFF, 3'b111, 12'hFFF, 12'h000);
        send_word(KIND_POLL, 3'd1, 32'h0000_0000, FLAGS_NONE, 12'hFFF, 12'h000);
        send_word(KIND_POLL, 3'd1, 32'h0000_0001, FLAGS_NONE, 12'hFFF, 12'h000);
        // A clear records its time, which the next poll measures against.
        send_word(KIND_CLEAR, 3'd1, 32'h8000_0000, 3'b111, 12'hFFF, 12'hFFF);
        send_word(KIND_POLL, 3'd1, 32'h8000_0001, F_END, 12'd1, 12'd1);
        send_word(KIND_CLEAR, 3'd7, 32'h1234_5678, 3'b101, 12'hABC, 12'h555);
        send_word(KIND_POLL, 3'd7, 32'h1234_567D, F_END, 12'h000, 12'h000);
        // Move outranks end, and start outranks end.
        send_word(KIND_POLL, 3'd7, 32'h1234_5680, F_MOVE | F_END, 12'hABC, 12'h555);
        send_word(KIND_POLL, 3'd7, 32'h1234_5690, F_START | F_END, 12'hABC, 12'h555);
        send_word(KIND_POLL, 3'd7, 32'h1234_56A0, F_END, 12'h800, 12'h7FF);
        // Clearing a task mid-touch forgets the finger.
        send_word(KIND_POLL, 3'd2, 32'd10, F_START, 12'd3, 12'd3);
        send_word(KIND_CLEAR, 3'd2, 32'd20, FLAGS_NONE, 12'd0, 12'd0);
        send_word(KIND_POLL, 3'd2, 32'd30, F_MOVE, 12'd3, 12'd3);
        drain();

        // Random part: each phase takes a new limit and its own idling pattern.
        phase_limit = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd300,
                        16'($urandom_range(2000))};
        phase_send  = '{0, 63, 0, 16, 0, 16};
        phase_recv  = '{0, 0, 63, 16, 0, 16};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_starve_limit(phase_limit[p]);
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_recv[p];
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Halfway through, the sender holds off until the block runs dry.
                if (n == PHASE_WORDS / 2)
                    drain();
                random_word();
            end
            drain();
        end

        if (tracker.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/tes_pkg.sv
design/touch_event_sanitizer_unit.sv
verif/touch_event_sanitizer_unit_test.sv
